// ----- hdl/pra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types and constants for the page run allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

  localparam int REGION_PAGES = 1024;
  localparam int IDX_W        = $clog2(REGION_PAGES);
  localparam int CNT_W        = $clog2(REGION_PAGES + 1);
  localparam int PAGE_SHIFT   = 12;
  localparam int FLOOR_W      = 20;

  localparam logic [31:0]        ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0]        PAGE_MASK   = 32'hFFFF_F000;
  localparam logic [31:0]        OFFSET_MASK = 32'h0000_0FFF;
  localparam logic [FLOOR_W:0]   ADDR_PAGES  = 21'h10_0000;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 20'd262144;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_INVAL = 2'd1;
  localparam logic [1:0] STATUS_NOFIT = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // bitmap port: one write and one read address per cycle
  typedef struct packed {
    logic we;
    idx_t waddr;
    logic wbit;
    idx_t raddr;
  } mem_req_t;

endpackage

// ----- hdl/pra_bitmap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_bitmap_ram
// Page occupancy bitmap: one bit per page, one write and one registered read.
// ----------------------------------------------------------------------------
module pra_bitmap_ram import pra_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic     rdata_o
);

  logic mem_q [REGION_PAGES];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wbit;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/page_run_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_run_allocator
// First-fit contiguous page allocator, scanning the region from the top down.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       request    in_valid_i / in_stall_o     opcode_i, first_arg_i, second_arg_i
//  out      result     out_valid_o / out_stall_i   status_o, result_value_o
//  cfg      write      cfg_we_i                    cfg_wdata_i (region_floor_page)
//
//  Map: a check step, then a scan of the live entries, one bitmap entry per
//  cycle, then the pages are marked and the base address is formed.
//  Unmap: check steps U0 to U3, then the pages are cleared.
//  All arithmetic checks share one 33-bit adder; the bitmap port sets the
//  walk at one entry a cycle. One request is worked on at a time.
//  After reset a clearing pass writes all 1024 entries with in_stall_o
//  high. A finished result waits in the output register while
//  the next request is taken.
// ----------------------------------------------------------------------------
module page_run_allocator import pra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FLOOR_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [31:0]        first_arg_i,
  input  logic [31:0]        second_arg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        result_value_o
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_M0    = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_MARK  = 4'd4;
  localparam logic [3:0] ST_BASE  = 4'd5;
  localparam logic [3:0] ST_U0    = 4'd6;
  localparam logic [3:0] ST_U1    = 4'd7;
  localparam logic [3:0] ST_U2    = 4'd8;
  localparam logic [3:0] ST_U3    = 4'd9;
  localparam logic [3:0] ST_CLEAR = 4'd10;
  localparam logic [3:0] ST_RESP  = 4'd11;

  logic [3:0]         state_q;
  logic [FLOOR_W-1:0] floor_q;

  logic               op_q;
  logic [31:0]        arg1_q;
  logic [31:0]        arg2_q;
  cnt_t               live_q;
  cnt_t               pages_q;
  logic [31:0]        tmp_q;
  idx_t               base_q;
  logic [1:0]         res_status_q;
  logic [31:0]        res_value_q;

  cnt_t               work_idx_q;
  cnt_t               stop_q;
  idx_t               scan_addr_q;
  logic               issue_q;
  logic               chk_vld_q;
  idx_t               chk_idx_q;
  cnt_t               run_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [31:0]        out_value_q;

  logic               in_acc;
  logic               out_load;
  logic [FLOOR_W:0]   room;
  cnt_t               live_now;
  logic [31:0]        floor_b;
  logic [31:0]        alu_a;
  logic [31:0]        alu_b;
  logic               alu_cin;
  logic [32:0]        alu_sum;
  logic               rd_bit;
  cnt_t               run_next;
  mem_req_t           mem_req;

  // pages that exist below the 4 GB top, capped at the region size
  assign room     = ADDR_PAGES - {1'b0, floor_q};
  assign live_now = (room < (FLOOR_W+1)'(REGION_PAGES)) ? CNT_W'(room)
                                                         : CNT_W'(REGION_PAGES);
  assign floor_b  = {floor_q, 12'h000};

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // shared adder
  always_comb begin
    alu_a   = arg1_q;
    alu_b   = OFFSET_MASK;
    alu_cin = 1'b0;
    case (state_q)
      ST_M0:   begin alu_a = arg1_q; alu_b = OFFSET_MASK; end
      ST_U0:   begin alu_a = arg2_q; alu_b = OFFSET_MASK; end
      ST_U1:   begin alu_a = arg1_q; alu_b = tmp_q; end
      ST_U2:   begin alu_a = arg1_q; alu_b = ~floor_b; alu_cin = 1'b1; end
      ST_U3:   begin alu_a = tmp_q;  alu_b = ~floor_b; alu_cin = 1'b1; end
      ST_BASE: begin
        alu_a = {{(32-FLOOR_W){1'b0}}, floor_q};
        alu_b = {{(32-IDX_W){1'b0}}, base_q};
      end
      default: begin alu_a = arg1_q; alu_b = OFFSET_MASK; end
    endcase
  end
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_cin};

  assign run_next = rd_bit ? '0 : run_q + CNT_W'(1);

  always_comb begin
    mem_req.we    = (state_q == ST_INIT) || (state_q == ST_MARK) || (state_q == ST_CLEAR);
    mem_req.waddr = work_idx_q[IDX_W-1:0];
    mem_req.wbit  = (state_q == ST_MARK);
    mem_req.raddr = scan_addr_q;
  end

  pra_bitmap_ram u_bitmap (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_bit)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      floor_q     <= FLOOR_RESET;
      work_idx_q  <= '0;
      stop_q      <= '0;
      scan_addr_q <= '0;
      issue_q     <= 1'b0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        floor_q <= cfg_wdata_i;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // scan read pipeline: entry read this cycle is checked next cycle
      chk_vld_q <= (state_q == ST_SCAN) && issue_q;
      chk_idx_q <= scan_addr_q;
      if (state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q - IDX_W'(1);
        issue_q     <= (scan_addr_q != '0);
      end

      case (state_q)
        ST_INIT: begin
          work_idx_q <= work_idx_q + CNT_W'(1);
          if (work_idx_q == CNT_W'(REGION_PAGES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (opcode_i == OP_MAP) ? ST_M0 : ST_U0;
          end
        end
        ST_M0: begin
          if ((arg1_q == '0) || (arg2_q != '0) ||
              (alu_sum[32:PAGE_SHIFT] > {{(33-PAGE_SHIFT-CNT_W){1'b0}}, live_q})) begin
            state_q <= ST_RESP;
          end else begin
            state_q     <= ST_SCAN;
            scan_addr_q <= IDX_W'(live_q - CNT_W'(1));
            issue_q     <= 1'b1;
            run_q       <= '0;
          end
        end
        ST_SCAN: begin
          if (chk_vld_q) begin
            run_q <= run_next;
            if (!rd_bit && (run_next == pages_q)) begin
              state_q    <= ST_MARK;
              work_idx_q <= {{(CNT_W-IDX_W){1'b0}}, chk_idx_q};
              stop_q     <= {{(CNT_W-IDX_W){1'b0}}, chk_idx_q} + pages_q;
            end else if (chk_idx_q == '0) begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_MARK: begin
          work_idx_q <= work_idx_q + CNT_W'(1);
          if (work_idx_q + CNT_W'(1) == stop_q) begin
            state_q <= ST_BASE;
          end
        end
        ST_BASE: begin
          state_q <= ST_RESP;
        end
        ST_U0: begin
          if ((arg2_q == '0) || ((arg1_q & OFFSET_MASK) != '0)) begin
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_U1;
          end
        end
        ST_U1: begin
          // wrapped end or rounded span of zero
          if (alu_sum[32] || (tmp_q == '0)) begin
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_U2;
          end
        end
        ST_U2: begin
          work_idx_q <= alu_sum[PAGE_SHIFT +: CNT_W];
          state_q    <= alu_sum[32] ? ST_U3 : ST_RESP;
        end
        ST_U3: begin
          stop_q <= alu_sum[PAGE_SHIFT +: CNT_W];
          if (alu_sum[31:PAGE_SHIFT] > {{(32-PAGE_SHIFT-CNT_W){1'b0}}, live_q}) begin
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          work_idx_q <= work_idx_q + CNT_W'(1);
          if (work_idx_q + CNT_W'(1) == stop_q) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_i;
      arg1_q <= first_arg_i;
      arg2_q <= second_arg_i;
      live_q <= live_now;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
    case (state_q)
      ST_M0: begin
        pages_q      <= alu_sum[PAGE_SHIFT +: CNT_W];
        res_status_q <= STATUS_INVAL;
        res_value_q  <= ALL_ONES;
      end
      ST_SCAN: begin
        if (chk_vld_q && !rd_bit && (run_next == pages_q)) begin
          base_q <= chk_idx_q;
        end
        res_status_q <= STATUS_NOFIT;
        res_value_q  <= ALL_ONES;
      end
      ST_BASE: begin
        res_status_q <= STATUS_OK;
        res_value_q  <= {alu_sum[FLOOR_W-1:0], 12'h000};
      end
      ST_U0: begin
        tmp_q        <= alu_sum[31:0] & PAGE_MASK;
        res_status_q <= STATUS_INVAL;
        res_value_q  <= '0;
      end
      ST_U1: begin
        tmp_q <= alu_sum[31:0];
      end
      ST_CLEAR: begin
        res_status_q <= STATUS_OK;
        res_value_q  <= '0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_value_o = out_value_q;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_acc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("accepted request did not start work");

  a_run_below_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (run_q < pages_q))
    else $error("scan run length reached request size without leaving scan");

  a_mark_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> (work_idx_q < live_q))
    else $error("mark outside live region");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("result loaded outside response state");

  a_op_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_MARK || state_q == ST_BASE) |-> (op_q == OP_MAP))
    else $error("map walk running for an unmap request");

endmodule
